// ===== rtl/core/kmeans_pkg.sv =====
`timescale 1ns / 1ps

package kmeans_pkg;

  // Default sizes
  localparam int DEF_MAX_POINTS   = 1024;
  localparam int DEF_MAX_CLUSTERS = 16;
  localparam int DEF_MAX_DIM      = 16;
  localparam int DEF_VALUE_BITS   = 16;

  // Energy accumulator
  localparam int              ENERGY_W   = 46;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  // Squared terms saturate once the magnitude reaches 2^23
  localparam int MAG_BITS = 23;

  // Command codes
  typedef enum logic [2:0] {
    KIND_LOAD_POINT  = 3'd0,
    KIND_LOAD_MEAN   = 3'd1,
    KIND_RUN         = 3'd2,
    KIND_READ_MEAN   = 3'd3,
    KIND_READ_ASSIGN = 3'd4
  } kind_t;

  // Register map (word index)
  typedef enum logic [1:0] {
    REG_POINT_COUNT   = 2'd0,
    REG_CLUSTER_COUNT = 2'd1,
    REG_DIM_COUNT     = 2'd2,
    REG_ITER_LIMIT    = 2'd3
  } reg_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN_INIT,
    ST_ITER_START,
    ST_ASSIGN,
    ST_ADRAIN,
    ST_SCLR,
    ST_SUM_A,
    ST_SUM_C,
    ST_SUM_R,
    ST_SUM_W,
    ST_MEAN_R,
    ST_MEAN_L,
    ST_MEAN_D,
    ST_MEAN_W,
    ST_ITER_END,
    ST_FIN
  } state_t;

endpackage

// ===== rtl/core/kmeans_lloyd_clustering.sv =====
`timescale 1ns / 1ps

// Lloyd k-means engine.
// Commands enter on start/kind/point_index/cluster_index/dim_index/value and
// are taken at a clock edge with start high and busy low. Every command gives
// one result, marked by done for one cycle; the receiver cannot stall it.
// Loads and reads do not raise busy: done follows the accepting edge, and a
// new command may be taken every cycle while busy is low.
// A run walks the point, mean, sum and assignment memories. Per iteration:
//   assign: one element per cycle through a 3-stage pipe, then a drain
//   clear sums, then accumulate each point into its cluster's sums
//   update: each sum divided by its count in the bit-serial divider
//   (skipped for empty clusters); ST_ITER_START and ST_ITER_END bracket each
//   iteration, and ST_RUN_INIT and ST_FIN bracket the run.
// busy stays high for the whole run; done pulses once at the end.
// Registers must be written over the APB port only while the block is idle;
// the block does not enforce it. After reset all MAX_POINTS assignment
// entries are cleared, one a cycle, with busy high; register writes are taken.

module kmeans_lloyd_clustering #(
  parameter int MAX_POINTS   = kmeans_pkg::DEF_MAX_POINTS,
  parameter int MAX_CLUSTERS = kmeans_pkg::DEF_MAX_CLUSTERS,
  parameter int MAX_DIM      = kmeans_pkg::DEF_MAX_DIM,
  parameter int VALUE_BITS   = kmeans_pkg::DEF_VALUE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [3:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           kind,
  input  logic [9:0]                           point_index,
  input  logic [3:0]                           cluster_index,
  input  logic [3:0]                           dim_index,
  input  logic signed [15:0]                   value,
  output logic                                 done,
  output logic signed [15:0]                   mean_value,
  output logic [3:0]                           assigned_cluster,
  output logic [10:0]                          member_count,
  output logic [15:0]                          iterations_done,
  output logic [kmeans_pkg::ENERGY_W-1:0]      total_energy
);

  import kmeans_pkg::*;

  localparam int PW  = $clog2(MAX_POINTS);
  localparam int KW  = $clog2(MAX_CLUSTERS);
  localparam int DW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int KCW = $clog2(MAX_CLUSTERS + 1);
  localparam int DCW = $clog2(MAX_DIM + 1);
  localparam int LB  = (VALUE_BITS < 16) ? VALUE_BITS : 16;
  localparam int SW  = VALUE_BITS + PCW;
  localparam int QCW = $clog2(SW + 1);

  // Configuration registers
  logic [10:0] cfg_points;
  logic [4:0]  cfg_clusters;
  logic [4:0]  cfg_dims;
  logic [15:0] cfg_limit;

  // Sequencer and counters
  state_t          state, state_next;
  logic [PW-1:0]   p;
  logic [KW-1:0]   k;
  logic [DW-1:0]   d;
  logic [KW-1:0]   c;

  // Run results
  logic [ENERGY_W-1:0] energy_reg;
  logic [15:0]         iteration_reg;
  logic [ENERGY_W-1:0] e1;
  logic [PCW-1:0]      count [MAX_CLUSTERS];

  // Distance pipeline
  logic                s1_valid, s1_ld, s1_lk, s1_zero;
  logic [KW-1:0]       s1_k;
  logic [PW-1:0]       s1_p;
  logic                s2_valid, s2_ld, s2_lk, s2_big;
  logic [KW-1:0]       s2_k;
  logic [PW-1:0]       s2_p;
  logic [ENERGY_W-1:0] s2_prod;
  logic [ENERGY_W-1:0] acc, best;
  logic [KW-1:0]       bi;

  // Divider
  logic [SW-1:0]  dq;
  logic [PCW-1:0] rem;
  logic [PCW-1:0] div;
  logic           neg;
  logic [QCW-1:0] steps;

  // Result staging
  logic [2:0]  r_kind;
  logic        r_mean_ok, r_asg_ok, r_ci_ok;
  logic [KW-1:0] r_ci;

  // Memory ports
  logic                  pt_we, mn_we, sm_we, as_we;
  logic [PW+DW-1:0]      pt_waddr, pt_raddr;
  logic [KW+DW-1:0]      mn_waddr, mn_raddr, sm_waddr, sm_raddr;
  logic [PW-1:0]         as_waddr, as_raddr;
  logic [VALUE_BITS-1:0] pt_wdata, pt_rdata, mn_wdata, mn_rdata;
  logic [SW-1:0]         sm_wdata, sm_rdata;
  logic [KW-1:0]         as_wdata, as_rdata;

  // Effective sizes, saturated to the build limits
  logic [PCW-1:0] n_eff;
  logic [KCW-1:0] kc_sat, kc_eff;
  logic [DCW-1:0] dims_eff;
  logic [PW-1:0]  p_end;
  logic [KW-1:0]  k_end;
  logic [DW-1:0]  d_end;
  logic           d_last, k_last, p_last;

  assign n_eff    = (32'(cfg_points) > MAX_POINTS) ? PCW'(MAX_POINTS) : PCW'(cfg_points);
  assign kc_sat   = (32'(cfg_clusters) > MAX_CLUSTERS) ? KCW'(MAX_CLUSTERS)
                                                        : KCW'(cfg_clusters);
  assign kc_eff   = (kc_sat == '0) ? KCW'(1) : kc_sat;
  assign dims_eff = (32'(cfg_dims) > MAX_DIM) ? DCW'(MAX_DIM) : DCW'(cfg_dims);
  assign p_end    = (n_eff == '0) ? '0 : PW'(n_eff - PCW'(1));
  assign k_end    = KW'(kc_eff - KCW'(1));
  assign d_end    = (dims_eff == '0) ? '0 : DW'(dims_eff - DCW'(1));
  assign d_last   = (d == d_end);
  assign k_last   = (k == k_end);
  assign p_last   = (p == p_end);

  // Command decode
  logic                  acc_in;
  logic                  pt_ok, mn_ok, as_ok, ci_ok;
  logic signed [LB-1:0]  ld_raw;
  logic [VALUE_BITS-1:0] ld_val;

  assign acc_in = start && !busy;
  assign ci_ok  = (32'(cluster_index) < MAX_CLUSTERS);
  assign pt_ok  = (32'(point_index) < MAX_POINTS) && (32'(dim_index) < MAX_DIM);
  assign mn_ok  = ci_ok && (32'(dim_index) < MAX_DIM);
  assign as_ok  = (32'(point_index) < MAX_POINTS);
  assign ld_raw = value[LB-1:0];
  assign ld_val = VALUE_BITS'(ld_raw);

  // APB port
  logic apb_wr;
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_POINT_COUNT:   prdata = 32'(cfg_points);
      REG_CLUSTER_COUNT: prdata = 32'(cfg_clusters);
      REG_DIM_COUNT:     prdata = 32'(cfg_dims);
      REG_ITER_LIMIT:    prdata = 32'(cfg_limit);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_points   <= 11'd1024;
      cfg_clusters <= 5'd16;
      cfg_dims     <= 5'd16;
      cfg_limit    <= 16'd100;
    end else if (apb_wr) begin
      case (paddr[3:2])
        REG_POINT_COUNT:   cfg_points   <= pwdata[10:0];
        REG_CLUSTER_COUNT: cfg_clusters <= pwdata[4:0];
        REG_DIM_COUNT:     cfg_dims     <= pwdata[4:0];
        REG_ITER_LIMIT:    cfg_limit    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Distance stage 1 -> 2: difference and square
  logic signed [VALUE_BITS:0] diff;
  logic [32:0]                mag;
  logic [2*MAG_BITS-1:0]      sq;
  always_comb begin
    diff = $signed({pt_rdata[VALUE_BITS-1], pt_rdata})
         - $signed({mn_rdata[VALUE_BITS-1], mn_rdata});
    mag  = diff[VALUE_BITS] ? 33'(-diff) : 33'(diff);
    sq   = mag[MAG_BITS-1:0] * mag[MAG_BITS-1:0];
  end

  // Distance stage 3: accumulate, compare, commit
  logic [ENERGY_W:0]   acc_sum, e_sum;
  logic [ENERGY_W-1:0] cand_dist, fbest;
  logic                take;
  logic [KW-1:0]       fbi;
  always_comb begin
    acc_sum   = {1'b0, acc} + {1'b0, (s2_big ? ENERGY_MAX : s2_prod)};
    cand_dist = acc_sum[ENERGY_W] ? ENERGY_MAX : acc_sum[ENERGY_W-1:0];
    take      = (s2_k == '0) || (cand_dist < best);
    fbest     = take ? cand_dist : best;
    fbi       = take ? s2_k : bi;
    e_sum     = {1'b0, e1} + {1'b0, fbest};
  end

  // Divider step
  logic [PCW:0]  rem_sh;
  logic          ge;
  logic [SW-1:0] quot;
  always_comb begin
    rem_sh = {rem, dq[SW-1]};
    ge     = (rem_sh >= {1'b0, div});
    quot   = neg ? (~dq + SW'(1)) : dq;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:      if (p == PW'(MAX_POINTS - 1)) state_next = ST_IDLE;
      ST_IDLE:       if (acc_in && kind == KIND_RUN) state_next = ST_RUN_INIT;
      ST_RUN_INIT:   state_next = (cfg_limit == '0) ? ST_FIN : ST_ITER_START;
      ST_ITER_START: begin
        if (n_eff != '0) state_next = ST_ASSIGN;
        else state_next = (dims_eff == '0) ? ST_ITER_END : ST_SCLR;
      end
      ST_ASSIGN:     if (d_last && k_last && p_last) state_next = ST_ADRAIN;
      ST_ADRAIN: begin
        if (!s1_valid && !s2_valid) begin
          state_next = (dims_eff == '0) ? ST_ITER_END : ST_SCLR;
        end
      end
      ST_SCLR: begin
        if (d_last && k_last) state_next = (n_eff == '0) ? ST_MEAN_R : ST_SUM_A;
      end
      ST_SUM_A:      state_next = ST_SUM_C;
      ST_SUM_C:      state_next = ST_SUM_R;
      ST_SUM_R:      state_next = ST_SUM_W;
      ST_SUM_W: begin
        if (!d_last) state_next = ST_SUM_R;
        else state_next = p_last ? ST_MEAN_R : ST_SUM_A;
      end
      ST_MEAN_R:     state_next = ST_MEAN_L;
      ST_MEAN_L:     state_next = (count[k] == '0) ? ST_MEAN_W : ST_MEAN_D;
      ST_MEAN_D:     if (steps == QCW'(1)) state_next = ST_MEAN_W;
      ST_MEAN_W:     state_next = (d_last && k_last) ? ST_ITER_END : ST_MEAN_R;
      ST_ITER_END: begin
        if ((iteration_reg + 16'd1 == cfg_limit) || (e1 == energy_reg)) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_ITER_START;
        end
      end
      ST_FIN:        state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Memory control
  always_comb begin
    busy     = (state != ST_IDLE);
    pt_we    = acc_in && kind == KIND_LOAD_POINT && pt_ok;
    pt_waddr = {PW'(point_index), DW'(dim_index)};
    pt_wdata = ld_val;
    pt_raddr = {p, d};

    mn_we    = acc_in && kind == KIND_LOAD_MEAN && mn_ok;
    mn_waddr = {KW'(cluster_index), DW'(dim_index)};
    mn_wdata = ld_val;
    mn_raddr = {KW'(cluster_index), DW'(dim_index)};

    sm_we    = 1'b0;
    sm_waddr = {k, d};
    sm_wdata = '0;
    sm_raddr = {k, d};

    as_we    = 1'b0;
    as_waddr = p;
    as_wdata = '0;
    as_raddr = PW'(point_index);

    case (state)
      ST_CLEAR:  as_we = 1'b1;
      ST_ASSIGN: mn_raddr = {k, d};
      ST_SCLR:   sm_we = 1'b1;
      ST_SUM_A:  as_raddr = p;
      ST_SUM_R:  sm_raddr = {c, d};
      ST_SUM_W: begin
        sm_we    = 1'b1;
        sm_waddr = {c, d};
        sm_wdata = sm_rdata + SW'($signed(pt_rdata));
      end
      ST_MEAN_W: begin
        mn_we    = 1'b1;
        mn_waddr = {k, d};
        mn_wdata = (div == '0) ? '0 : VALUE_BITS'(quot);
      end
      default: ;
    endcase

    // Assignment commit from the distance pipe
    if (state != ST_CLEAR && s2_valid && s2_ld && s2_lk) begin
      as_we    = 1'b1;
      as_waddr = s2_p;
      as_wdata = fbi;
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      p             <= '0;
      k             <= '0;
      d             <= '0;
      energy_reg    <= ENERGY_MAX;
      iteration_reg <= '0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      done          <= 1'b0;
      for (int i = 0; i < MAX_CLUSTERS; i++) count[i] <= '0;
    end else begin
      state <= state_next;
      done  <= (acc_in && kind != KIND_RUN) || (state == ST_FIN);

      // issue tags
      s1_valid <= (state == ST_ASSIGN);
      s1_ld    <= d_last;
      s1_lk    <= k_last;
      s1_k     <= k;
      s1_p     <= p;
      s1_zero  <= (dims_eff == '0);

      // square stage
      s2_valid <= s1_valid;
      s2_ld    <= s1_ld;
      s2_lk    <= s1_lk;
      s2_k     <= s1_k;
      s2_p     <= s1_p;
      s2_big   <= !s1_zero && (mag[32:MAG_BITS] != '0);
      s2_prod  <= s1_zero ? '0 : ENERGY_W'(sq);

      // accumulate and pick nearest mean
      if (s2_valid) begin
        acc <= s2_ld ? '0 : cand_dist;
        if (s2_ld) begin
          best <= fbest;
          bi   <= fbi;
          if (s2_lk) begin
            count[fbi] <= count[fbi] + PCW'(1);
            e1         <= e_sum[ENERGY_W] ? ENERGY_MAX : e_sum[ENERGY_W-1:0];
          end
        end
      end

      case (state)
        ST_CLEAR:    p <= p + PW'(1);
        ST_RUN_INIT: begin
          energy_reg    <= ENERGY_MAX;
          iteration_reg <= '0;
        end
        ST_ITER_START: begin
          for (int i = 0; i < MAX_CLUSTERS; i++) count[i] <= '0;
          e1  <= '0;
          acc <= '0;
          p   <= '0;
          k   <= '0;
          d   <= '0;
        end
        ST_ASSIGN: begin
          if (d_last) begin
            d <= '0;
            if (k_last) begin
              k <= '0;
              p <= p + PW'(1);
            end else begin
              k <= k + KW'(1);
            end
          end else begin
            d <= d + DW'(1);
          end
        end
        ST_ADRAIN: begin
          k <= '0;
          d <= '0;
        end
        ST_SCLR, ST_MEAN_W: begin
          if (d_last) begin
            d <= '0;
            k <= k_last ? '0 : k + KW'(1);
          end else begin
            d <= d + DW'(1);
          end
          p <= '0;
        end
        ST_SUM_C: begin
          c <= as_rdata;
          d <= '0;
        end
        ST_SUM_W: begin
          if (d_last) begin
            d <= '0;
            p <= p + PW'(1);
          end else begin
            d <= d + DW'(1);
          end
        end
        ST_MEAN_L: begin
          neg   <= sm_rdata[SW-1];
          dq    <= sm_rdata[SW-1] ? (~sm_rdata + SW'(1)) : sm_rdata;
          rem   <= '0;
          div   <= count[k];
          steps <= QCW'(SW);
        end
        ST_MEAN_D: begin
          rem   <= ge ? PCW'(rem_sh - {1'b0, div}) : PCW'(rem_sh);
          dq    <= {dq[SW-2:0], ge};
          steps <= steps - QCW'(1);
        end
        ST_ITER_END: begin
          iteration_reg <= iteration_reg + 16'd1;
          energy_reg    <= e1;
        end
        default: ;
      endcase
    end
  end

  // Result staging
  always_ff @(posedge clk) begin
    if (acc_in) begin
      r_kind    <= kind;
      r_mean_ok <= mn_ok;
      r_asg_ok  <= as_ok;
      r_ci_ok   <= ci_ok;
      r_ci      <= KW'(cluster_index);
    end
  end

  logic signed [VALUE_BITS-1:0] mn_rs;
  assign mn_rs            = mn_rdata;
  assign mean_value       = (r_kind == KIND_READ_MEAN && r_mean_ok) ? 16'(mn_rs) : '0;
  assign assigned_cluster = (r_kind == KIND_READ_ASSIGN && r_asg_ok) ? 4'(as_rdata) : '0;
  assign member_count     = r_ci_ok ? 11'(count[r_ci]) : '0;
  assign iterations_done  = iteration_reg;
  assign total_energy     = energy_reg;

  // Memories
  kmeans_ram #(.WIDTH(VALUE_BITS), .DEPTH(2 ** (PW + DW))) u_point_ram (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  kmeans_ram #(.WIDTH(VALUE_BITS), .DEPTH(2 ** (KW + DW))) u_mean_ram (
    .clk(clk), .we(mn_we), .waddr(mn_waddr), .wdata(mn_wdata),
    .raddr(mn_raddr), .rdata(mn_rdata)
  );

  kmeans_ram #(.WIDTH(SW), .DEPTH(2 ** (KW + DW))) u_sum_ram (
    .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .raddr(sm_raddr), .rdata(sm_rdata)
  );

  kmeans_ram #(.WIDTH(KW), .DEPTH(2 ** PW)) u_asg_ram (
    .clk(clk), .we(as_we), .waddr(as_waddr), .wdata(as_wdata),
    .raddr(as_raddr), .rdata(as_rdata)
  );

endmodule

// ===== rtl/core/kmeans_ram.sv =====
`timescale 1ns / 1ps

module kmeans_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/kmeans_chk.sv =====
`timescale 1ns / 1ps

module kmeans_chk (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [2:0] kind,
  input logic       done,
  input logic       pready
);

  import kmeans_pkg::*;

  // Every command but a run answers on the next cycle
  a_quick_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind != KIND_RUN |=> done)
    else $error("load/read transaction gave no result");

  // A run holds off new commands
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == KIND_RUN |=> busy && !done)
    else $error("run did not go busy");

  // Assignment clear follows reset
  a_reset_busy: assert property (@(posedge clk)
    $past(rst) |-> busy)
    else $error("not busy after reset");

  // Register port never waits
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind kmeans_lloyd_clustering kmeans_chk u_kmeans_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
  .done(done), .pready(pready)
);

// ===== sim/kmeans_lloyd_clustering_checker.sv =====
`timescale 1ns / 1ps

// Watches the register port and the command channel, predicts each result
// of the clustering engine and compares it with the one that comes out.
module kmeans_lloyd_clustering_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  input  logic                               pready,
  input  logic                               start,
  input  logic                               busy,
  input  logic [2:0]                         kind,
  input  logic [9:0]                         point_index,
  input  logic [3:0]                         cluster_index,
  input  logic [3:0]                         dim_index,
  input  logic signed [15:0]                 value,
  input  logic                               done,
  input  logic signed [15:0]                 mean_value,
  input  logic [3:0]                         assigned_cluster,
  input  logic [10:0]                        member_count,
  input  logic [15:0]                        iterations_done,
  input  logic [kmeans_pkg::ENERGY_W-1:0]    total_energy,
  output int                                 errors,
  output int                                 outstanding
);
  import kmeans_pkg::*;

  localparam int NPTS = DEF_MAX_POINTS;
  localparam int NCL  = DEF_MAX_CLUSTERS;
  localparam int NDIM = DEF_MAX_DIM;
  localparam longint unsigned EMAX = (64'd1 << ENERGY_W) - 1;

  typedef struct {
    logic signed [15:0]    mean;
    logic [3:0]            cluster;
    logic [10:0]           count;
    logic [15:0]           iters;
    logic [ENERGY_W-1:0]   energy;
  } kmeans_result_t;

  // Shadow of the engine state
  int              pts    [NPTS][NDIM];
  int              means  [NCL][NDIM];
  longint          sums   [NCL][NDIM];
  logic [3:0]      labels [NPTS];
  int              counts [NCL];
  longint unsigned energy;
  int              iters;
  int              cfg_points, cfg_clusters, cfg_dims, cfg_limit;

  kmeans_result_t  expected_q[$];

  assign outstanding = expected_q.size();

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > EMAX || s < a) ? EMAX : s;
  endfunction

  function automatic longint unsigned sq_dist(int p, int k, int dims);
    longint unsigned acc;
    longint          diff;
    longint unsigned mag;
    acc = 0;
    for (int d = 0; d < dims; d++) begin
      diff = longint'(pts[p][d]) - longint'(means[k][d]);
      mag  = diff < 0 ? -diff : diff;
      if (mag >= (64'd1 << MAG_BITS)) return EMAX;
      acc = sat_sum(acc, mag * mag);
    end
    return acc;
  endfunction

  // Lloyd iterations until the limit or until energy stops changing
  task automatic cluster_points();
    int n, kc, dims, it, bi;
    longint unsigned e, e1, best, cand;
    bit changed;
    n    = cfg_points > NPTS ? NPTS : cfg_points;
    kc   = cfg_clusters > NCL ? NCL : cfg_clusters;
    dims = cfg_dims > NDIM ? NDIM : cfg_dims;
    if (kc == 0) kc = 1;
    e = EMAX;
    it = 0;
    changed = 1;
    while (it < cfg_limit && changed) begin
      e1 = 0;
      foreach (counts[k]) counts[k] = 0;
      for (int p = 0; p < n; p++) begin
        best = sq_dist(p, 0, dims);
        bi = 0;
        for (int k = 1; k < kc; k++) begin
          cand = sq_dist(p, k, dims);
          if (cand < best) begin
            best = cand;
            bi = k;
          end
        end
        labels[p] = 4'(bi);
        counts[bi]++;
        e1 = sat_sum(e1, best);
      end
      for (int k = 0; k < kc; k++)
        for (int d = 0; d < dims; d++) sums[k][d] = 0;
      for (int p = 0; p < n; p++)
        for (int d = 0; d < dims; d++) sums[labels[p]][d] += pts[p][d];
      for (int k = 0; k < kc; k++)
        for (int d = 0; d < dims; d++)
          means[k][d] = counts[k] != 0 ? int'(sums[k][d] / longint'(counts[k])) : 0;
      it++;
      changed = (e1 != e);
      e = e1;
    end
    iters  = it;
    energy = e;
  endtask

  task automatic report(string what, longint unsigned exp_v, longint unsigned got_v);
    $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    errors++;
  endtask

  initial begin
    errors = 0;
    foreach (sums[k, d]) sums[k][d] = 0;
    foreach (labels[p]) labels[p] = 0;
    foreach (counts[k]) counts[k] = 0;
    energy = EMAX;
    iters = 0;
    cfg_points = 1024;
    cfg_clusters = 16;
    cfg_dims = 16;
    cfg_limit = 100;
  end

  always @(posedge clk) begin
    kmeans_result_t r, x;
    if (!rst) begin
      // Compare a finished transaction first: it belongs to an earlier command
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result: mean %0d cluster %0d count %0d", $time,
                   mean_value, assigned_cluster, member_count);
          errors++;
        end else begin
          x = expected_q.pop_front();
          if (mean_value !== x.mean) report("mean_value", x.mean, mean_value);
          if (assigned_cluster !== x.cluster)
            report("assigned_cluster", x.cluster, assigned_cluster);
          if (member_count !== x.count) report("member_count", x.count, member_count);
          if (iterations_done !== x.iters)
            report("iterations_done", x.iters, iterations_done);
          if (total_energy !== x.energy) report("total_energy", x.energy, total_energy);
        end
      end

      // Register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_t'(paddr[3:2]))
          REG_POINT_COUNT:   cfg_points   = int'(pwdata[10:0]);
          REG_CLUSTER_COUNT: cfg_clusters = int'(pwdata[4:0]);
          REG_DIM_COUNT:     cfg_dims     = int'(pwdata[4:0]);
          REG_ITER_LIMIT:    cfg_limit    = int'(pwdata[15:0]);
          default: ;
        endcase
      end

      // Accepted command
      if (start && !busy) begin
        r.mean = 0;
        r.cluster = 0;
        case (kind)
          KIND_LOAD_POINT:  pts[point_index][dim_index] = value;
          KIND_LOAD_MEAN:   means[cluster_index][dim_index] = value;
          KIND_RUN:         cluster_points();
          KIND_READ_MEAN:   r.mean = 16'(means[cluster_index][dim_index]);
          KIND_READ_ASSIGN: r.cluster = labels[point_index];
          default: ;
        endcase
        r.count  = 11'(counts[cluster_index]);
        r.iters  = 16'(iters);
        r.energy = ENERGY_W'(energy);
        expected_q.push_back(r);
      end
    end
  end

endmodule

// ===== sim/kmeans_lloyd_clustering_test.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the clustering engine.
module kmeans_lloyd_clustering_test;
  import kmeans_pkg::*;

  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic start = 0;
  logic busy;
  logic [2:0] kind = 0;
  logic [9:0] point_index = 0;
  logic [3:0] cluster_index = 0;
  logic [3:0] dim_index = 0;
  logic signed [15:0] value = 0;
  logic done;
  logic signed [15:0] mean_value;
  logic [3:0] assigned_cluster;
  logic [10:0] member_count;
  logic [15:0] iterations_done;
  logic [ENERGY_W-1:0] total_energy;
  int errors, outstanding;

  always #10 clk = ~clk;

  kmeans_lloyd_clustering u_dut (.*);

  kmeans_lloyd_clustering_checker u_check (.*);

  // Which entries hold a written value; only those may be read or clustered
  bit pt_valid [1024][16];
  bit mn_valid [16][16];
  int n_in_use, k_in_use, d_in_use;
  bit gaps_on;
  int n_items, n_runs, n_reads, n_loads;
  int center [4];

  task automatic write_reg(reg_t idx, int data);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  // One command transaction; returns right after the accepting edge
  task automatic issue(logic [2:0] k, int p, int c, int d, int v);
    if (gaps_on) begin
      while ($urandom_range(99) < 36) begin
        start <= 0;
        @(posedge clk);
      end
    end
    start <= 1;
    kind <= k;
    point_index <= 10'(p);
    cluster_index <= 4'(c);
    dim_index <= 4'(d);
    value <= 16'(v);
    do @(posedge clk); while (busy);
    n_items++;
    case (k)
      KIND_LOAD_POINT: begin
        pt_valid[p][d] = 1;
        n_loads++;
      end
      KIND_LOAD_MEAN: begin
        mn_valid[c][d] = 1;
        n_loads++;
      end
      KIND_RUN: begin
        for (int i = 0; i < k_in_use; i++)
          for (int j = 0; j < d_in_use; j++) mn_valid[i][j] = 1;
        n_runs++;
      end
      KIND_READ_MEAN, KIND_READ_ASSIGN: n_reads++;
      default: ;
    endcase
  endtask

  // Drain: every expected result must be back before the next setting
  task automatic settle();
    start <= 0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
  endtask

  task automatic configure(int np, int kc, int dc, int lim);
    write_reg(REG_POINT_COUNT, np);
    write_reg(REG_CLUSTER_COUNT, kc);
    write_reg(REG_DIM_COUNT, dc);
    write_reg(REG_ITER_LIMIT, lim);
    n_in_use = np > 1024 ? 1024 : np;
    k_in_use = kc > 16 ? 16 : (kc == 0 ? 1 : kc);
    d_in_use = dc > 16 ? 16 : dc;
  endtask

  function automatic int coord();
    if ($urandom_range(3) == 0) return $urandom_range(16'hFFFF);
    return center[$urandom_range(3)] + $signed($urandom_range(400)) - 200;
  endfunction

  // Fill every entry that a run will touch
  task automatic load_data_set();
    for (int p = 0; p < n_in_use; p++)
      for (int d = 0; d < d_in_use; d++) issue(KIND_LOAD_POINT, p, 0, d, coord());
    for (int k = 0; k < k_in_use; k++)
      for (int d = 0; d < d_in_use; d++) issue(KIND_LOAD_MEAN, 0, k, d, coord());
  endtask

  task automatic random_ops(int count);
    int sel, p, c, d;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        // reload an entry in use, or any entry at all
        if ($urandom_range(3) != 0 && n_in_use > 0 && d_in_use > 0)
          issue(KIND_LOAD_POINT, $urandom_range(n_in_use - 1), $urandom_range(15),
                $urandom_range(d_in_use - 1), coord());
        else
          issue(KIND_LOAD_POINT, $urandom_range(1023), $urandom_range(15),
                $urandom_range(15), $urandom_range(16'hFFFF));
      end else if (sel < 38) begin
        issue(KIND_LOAD_MEAN, $urandom_range(1023), $urandom_range(k_in_use - 1),
              d_in_use > 0 ? $urandom_range(d_in_use - 1) : 0, coord());
      end else if (sel < 50) begin
        issue(KIND_RUN, $urandom_range(1023), $urandom_range(15), $urandom_range(15),
              $urandom_range(16'hFFFF));
      end else if (sel < 75) begin
        c = $urandom_range(15);
        d = $urandom_range(15);
        for (int t = 0; t < 8 && !mn_valid[c][d]; t++) begin
          c = $urandom_range(k_in_use - 1);
          d = d_in_use > 0 ? $urandom_range(d_in_use - 1) : 0;
        end
        if (mn_valid[c][d])
          issue(KIND_READ_MEAN, $urandom_range(1023), c, d, $urandom_range(16'hFFFF));
        else
          issue(KIND_READ_ASSIGN, $urandom_range(1023), c, d, 0);
      end else if (sel < 94) begin
        p = n_in_use > 0 && $urandom_range(3) != 0 ?
            $urandom_range(n_in_use - 1) : $urandom_range(1023);
        issue(KIND_READ_ASSIGN, p, $urandom_range(15), $urandom_range(15),
              $urandom_range(16'hFFFF));
      end else begin
        issue(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), $urandom_range(1023),
              $urandom_range(15), $urandom_range(15), $urandom_range(16'hFFFF));
      end
    end
  endtask

  initial begin
    int phase;
    n_items = 0;
    n_runs = 0;
    n_reads = 0;
    n_loads = 0;
    gaps_on = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, every command, spare codes, reads before any run
    configure(4, 2, 2, 100);
    issue(KIND_SPARE_LO, 0, 0, 0, 0);
    issue(KIND_READ_ASSIGN, 1023, 15, 15, 0);
    issue(KIND_LOAD_POINT, 0, 0, 0, -32768);
    issue(KIND_LOAD_POINT, 0, 0, 1, 32767);
    issue(KIND_LOAD_POINT, 1, 0, 0, 32767);
    issue(KIND_LOAD_POINT, 1, 0, 1, -32768);
    issue(KIND_LOAD_POINT, 2, 0, 0, 5);
    issue(KIND_LOAD_POINT, 2, 0, 1, 5);
    issue(KIND_LOAD_POINT, 3, 0, 0, -7);
    issue(KIND_LOAD_POINT, 3, 0, 1, 3);
    issue(KIND_LOAD_POINT, 1023, 15, 15, -1);
    issue(KIND_LOAD_MEAN, 0, 0, 0, 0);
    issue(KIND_LOAD_MEAN, 0, 0, 1, 0);
    issue(KIND_LOAD_MEAN, 0, 1, 0, 0);
    issue(KIND_LOAD_MEAN, 0, 1, 1, 0);
    issue(KIND_LOAD_MEAN, 0, 15, 15, 32767);
    issue(KIND_READ_MEAN, 0, 15, 15, 0);
    issue(KIND_RUN, 0, 0, 0, 0);
    issue(KIND_READ_MEAN, 0, 0, 0, 0);
    issue(KIND_READ_MEAN, 0, 1, 1, 0);
    issue(KIND_READ_ASSIGN, 0, 1, 0, 0);
    issue(KIND_READ_ASSIGN, 3, 0, 0, 0);
    issue(KIND_SPARE_HI, 1023, 15, 15, -1);
    settle();

    // Random phases with a new setting each time
    phase = 0;
    while (n_items < 1300) begin
      gaps_on = (phase != 1);
      foreach (center[i]) center[i] = $signed($urandom_range(60000)) - 30000;
      case (phase)
        0: configure(0, 0, 1, 5);
        1: configure(12, 3, 2, 0);
        2: configure(2047, 2, 1, 65535);
        3: configure(6, 31, 2, 6);
        4: configure(5, 2, 0, 4);
        5: configure(3, 16, 31, 3);
        6: configure(1, 1, 16, 2);
        default: configure($urandom_range(1, 20), $urandom_range(1, 4),
                           $urandom_range(1, 3), $urandom_range(0, 8));
      endcase
      load_data_set();
      if (phase == 2) begin
        issue(KIND_RUN, 0, 0, 0, 0);
        random_ops(10);
      end else begin
        random_ops(40);
      end
      settle();
      phase++;
    end

    settle();
    repeat (50) @(posedge clk);
    $display("Covered %0d commands: %0d loads, %0d runs, %0d reads, over %0d settings",
             n_items, n_loads, n_runs, n_reads, phase + 1);
    $display("Settings reached empty, saturated and full-size counts and zero limits");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("Timed out with %0d results outstanding", outstanding);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/kmeans_pkg.sv
rtl/core/kmeans_ram.sv
rtl/core/kmeans_lloyd_clustering.sv
rtl/core/kmeans_chk.sv
sim/kmeans_lloyd_clustering_checker.sv
sim/kmeans_lloyd_clustering_test.sv
